[hw/rtl/lpw_pkg.sv]
// ----------------------------------------------------------------------------
// lpw_pkg
// Shared widths and types for the per-pixel level weight block.
// ----------------------------------------------------------------------------
package lpw_pkg;

	localparam int PIX_W      = 16;              // Q4.12 channel value
	localparam int VAR_W      = 32;              // Q8.24 variance
	localparam int SQ_W       = 2 * PIX_W;       // squared channel difference
	localparam int RAD_W      = SQ_W + 1;        // square plus variance
	localparam int ROOT_STEPS = (RAD_W + 1) / 2; // one root bit per step
	localparam int RAD_SH_W   = 2 * ROOT_STEPS;  // radicand shift register
	localparam int MAG_W      = ROOT_STEPS;      // magnitude, Q5.12
	localparam int ROOT_REM_W = MAG_W + 4;       // root remainder with headroom
	localparam int FRAC_W     = 16;              // weight fraction bits
	localparam int WEIGHT_W   = FRAC_W + 1;      // weight, 0..65536
	localparam int IDX_W      = 6;               // level index field
	localparam int STEP_W     = 5;               // counts root and divide steps
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;

	// one classified level waiting for the root and store unit
	typedef struct packed {
		logic [RAD_W-1:0] radicand;
		logic             last;
	} level_job_t;

endpackage

[hw/rtl/lpw_if.sv]
// ----------------------------------------------------------------------------
// lpw channel interfaces
// Level input channel and weight output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lpw_level_if;
	logic                      valid;
	logic                      ready;
	logic [lpw_pkg::PIX_W-1:0] cur_red;
	logic [lpw_pkg::PIX_W-1:0] cur_green;
	logic [lpw_pkg::PIX_W-1:0] cur_blue;
	logic [lpw_pkg::PIX_W-1:0] next_red;
	logic [lpw_pkg::PIX_W-1:0] next_green;
	logic [lpw_pkg::PIX_W-1:0] next_blue;
	logic [lpw_pkg::VAR_W-1:0] pair_variance;
	logic                      variance_invalid;
	logic                      last_level;

	modport source (
		output valid, cur_red, cur_green, cur_blue, next_red, next_green, next_blue,
		output pair_variance, variance_invalid, last_level,
		input  ready
	);
	modport sink (
		input  valid, cur_red, cur_green, cur_blue, next_red, next_green, next_blue,
		input  pair_variance, variance_invalid, last_level,
		output ready
	);
endinterface

interface lpw_weight_if;
	logic                         valid;
	logic                         ready;
	logic [lpw_pkg::IDX_W-1:0]    level_index;
	logic [lpw_pkg::WEIGHT_W-1:0] level_weight;
	logic                         zero_total;
	logic                         last_weight;

	modport source (
		output valid, level_index, level_weight, zero_total, last_weight,
		input  ready
	);
	modport sink (
		input  valid, level_index, level_weight, zero_total, last_weight,
		output ready
	);
endinterface

[hw/rtl/lpw_ram.sv]
// ----------------------------------------------------------------------------
// lpw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lpw_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hw/rtl/lpw_front.sv]
// ----------------------------------------------------------------------------
// lpw_front
// Takes level beats, squares the channel differences and forms the radicand.
// ----------------------------------------------------------------------------
module lpw_front (
	input  logic                clk,
	input  logic                arst_n,
	lpw_level_if.sink           levels,
	output lpw_pkg::level_job_t job,
	output logic                job_valid,
	input  logic                job_ready
);

	logic                        valid_s1;
	logic [lpw_pkg::SQ_W-1:0]    sq_red_s1;
	logic [lpw_pkg::SQ_W-1:0]    sq_green_s1;
	logic [lpw_pkg::SQ_W-1:0]    sq_blue_s1;
	logic [lpw_pkg::VAR_W-1:0]   var_s1;
	logic                        last_s1;

	logic [lpw_pkg::PIX_W-1:0]   diff_red;
	logic [lpw_pkg::PIX_W-1:0]   diff_green;
	logic [lpw_pkg::PIX_W-1:0]   diff_blue;
	logic [lpw_pkg::SQ_W-1:0]    peak;
	logic                        take;

	always_comb begin
		diff_red   = (levels.cur_red >= levels.next_red) ?
			levels.cur_red - levels.next_red : levels.next_red - levels.cur_red;
		diff_green = (levels.cur_green >= levels.next_green) ?
			levels.cur_green - levels.next_green : levels.next_green - levels.cur_green;
		diff_blue  = (levels.cur_blue >= levels.next_blue) ?
			levels.cur_blue - levels.next_blue : levels.next_blue - levels.cur_blue;
	end

	assign levels.ready = !valid_s1 || job_ready;
	assign take         = levels.valid && levels.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (levels.ready) begin
			valid_s1 <= levels.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sq_red_s1   <= lpw_pkg::SQ_W'(diff_red) * lpw_pkg::SQ_W'(diff_red);
			sq_green_s1 <= lpw_pkg::SQ_W'(diff_green) * lpw_pkg::SQ_W'(diff_green);
			sq_blue_s1  <= lpw_pkg::SQ_W'(diff_blue) * lpw_pkg::SQ_W'(diff_blue);
			var_s1      <= levels.variance_invalid ? '0 : levels.pair_variance;
			last_s1     <= levels.last_level;
		end
	end

	always_comb begin
		peak = sq_red_s1;
		if (sq_green_s1 > peak) begin
			peak = sq_green_s1;
		end
		if (sq_blue_s1 > peak) begin
			peak = sq_blue_s1;
		end
	end

	assign job_valid    = valid_s1;
	assign job.radicand = lpw_pkg::RAD_W'(peak) + lpw_pkg::RAD_W'(var_s1);
	assign job.last     = last_s1;

endmodule

[hw/rtl/lpw_queue.sv]
// ----------------------------------------------------------------------------
// lpw_queue
// Short queue of classified levels between the front and the back.
// ----------------------------------------------------------------------------
module lpw_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  lpw_pkg::level_job_t push_data,
	input  logic                push_valid,
	output logic                push_ready,
	output lpw_pkg::level_job_t pop_data,
	output logic                pop_valid,
	input  logic                pop_ready
);

	lpw_pkg::level_job_t             mem_q [lpw_pkg::QUEUE_DEPTH];
	logic [lpw_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [lpw_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [lpw_pkg::QPTR_W:0]        fill_q;
	logic                            push;
	logic                            pop;

	assign push_ready = fill_q != (lpw_pkg::QPTR_W + 1)'(lpw_pkg::QUEUE_DEPTH);
	assign pop_valid  = fill_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[hw/rtl/lpw_back.sv]
// ----------------------------------------------------------------------------
// lpw_back
// Square root and store per level; on the last level, divides each stored
// magnitude by the total and drives the weight beats.
// ----------------------------------------------------------------------------
module lpw_back #(
	parameter int MAX_LEVELS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lpw_pkg::level_job_t         job,
	input  logic                        job_valid,
	output logic                        job_ready,
	output logic                        ram_we,
	output logic [((MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1)-1:0] ram_waddr,
	output logic [lpw_pkg::MAG_W-1:0]   ram_wdata,
	output logic [((MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1)-1:0] ram_raddr,
	input  logic [lpw_pkg::MAG_W-1:0]   ram_rdata,
	lpw_weight_if.source                weights
);

	localparam int AW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int CW = $clog2(MAX_LEVELS + 1);
	localparam int TW = lpw_pkg::MAG_W + $clog2(MAX_LEVELS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROOT,
		ST_FETCH,
		ST_LOAD,
		ST_DIVIDE,
		ST_EMIT
	} state_t;

	state_t                            state_q;
	logic [CW-1:0]                     count_q;
	logic [TW-1:0]                     total_q;
	logic [CW-1:0]                     k_q;
	logic                              last_job_q;
	logic [lpw_pkg::STEP_W-1:0]        step_q;
	logic [lpw_pkg::RAD_SH_W-1:0]      rad_q;
	logic [lpw_pkg::MAG_W-1:0]         root_q;
	logic [lpw_pkg::ROOT_REM_W-1:0]    rem_q;
	logic [lpw_pkg::WEIGHT_W-1:0]      dsh_q;
	logic [lpw_pkg::WEIGHT_W-1:0]      quo_q;
	logic [TW:0]                       drem_q;
	logic                              out_valid_q;
	logic [lpw_pkg::IDX_W-1:0]         out_index_q;
	logic [lpw_pkg::WEIGHT_W-1:0]      out_weight_q;
	logic                              out_zero_q;
	logic                              out_last_q;

	logic [lpw_pkg::ROOT_REM_W-1:0]    rem_sh;
	logic [lpw_pkg::ROOT_REM_W-1:0]    trial;
	logic                              root_bit;
	logic [lpw_pkg::MAG_W-1:0]         root_nx;
	logic [lpw_pkg::ROOT_REM_W-1:0]    rem_nx;
	logic [TW:0]                       drem_sh;
	logic                              quo_bit;
	logic [CW-1:0]                     k_nx;
	logic                              root_done;
	logic                              emit_fire;

	// one root bit per step, two radicand bits shifted in
	always_comb begin
		rem_sh   = {rem_q[lpw_pkg::ROOT_REM_W-3:0], rad_q[lpw_pkg::RAD_SH_W-1 -: 2]};
		trial    = lpw_pkg::ROOT_REM_W'({root_q, 2'b01});
		root_bit = rem_sh >= trial;
		rem_nx   = root_bit ? rem_sh - trial : rem_sh;
		root_nx  = {root_q[lpw_pkg::MAG_W-2:0], root_bit};
	end

	// one quotient bit per step
	always_comb begin
		drem_sh = {drem_q[TW-1:0], dsh_q[lpw_pkg::WEIGHT_W-1]};
		quo_bit = drem_sh >= {1'b0, total_q};
	end

	assign root_done = (state_q == ST_ROOT) &&
		(step_q == lpw_pkg::STEP_W'(lpw_pkg::ROOT_STEPS - 1));
	assign k_nx      = k_q + CW'(1);
	assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || weights.ready);

	assign job_ready = state_q == ST_IDLE;
	assign ram_we    = root_done;
	assign ram_waddr = count_q[AW-1:0];
	assign ram_wdata = root_nx;
	assign ram_raddr = k_q[AW-1:0];

	assign weights.valid        = out_valid_q;
	assign weights.level_index  = out_index_q;
	assign weights.level_weight = out_weight_q;
	assign weights.zero_total   = out_zero_q;
	assign weights.last_weight  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			total_q      <= '0;
			k_q          <= '0;
			last_job_q   <= 1'b0;
			step_q       <= '0;
			rad_q        <= '0;
			root_q       <= '0;
			rem_q        <= '0;
			dsh_q        <= '0;
			quo_q        <= '0;
			drem_q       <= '0;
			out_valid_q  <= 1'b0;
			out_index_q  <= '0;
			out_weight_q <= '0;
			out_zero_q   <= 1'b0;
			out_last_q   <= 1'b0;
		end else begin
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (weights.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						last_job_q <= job.last;
						if (count_q < CW'(MAX_LEVELS)) begin
							rad_q   <= lpw_pkg::RAD_SH_W'(job.radicand);
							root_q  <= '0;
							rem_q   <= '0;
							step_q  <= '0;
							state_q <= ST_ROOT;
						end else if (job.last) begin
							// store full: level dropped, still closes the pixel
							state_q <= ST_FETCH;
						end
					end
				end
				ST_ROOT: begin
					rad_q  <= {rad_q[lpw_pkg::RAD_SH_W-3:0], 2'b00};
					root_q <= root_nx;
					rem_q  <= rem_nx;
					step_q <= step_q + 1'b1;
					if (root_done) begin
						total_q <= total_q + TW'(root_nx);
						count_q <= count_q + CW'(1);
						state_q <= last_job_q ? ST_FETCH : ST_IDLE;
					end
				end
				ST_FETCH: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					// magnitude never exceeds the total, so the quotient fits 17 bits
					drem_q  <= (TW + 1)'(ram_rdata[lpw_pkg::MAG_W-1:1]);
					dsh_q   <= {ram_rdata[0], {lpw_pkg::FRAC_W{1'b0}}};
					quo_q   <= '0;
					step_q  <= '0;
					state_q <= (total_q == '0) ? ST_EMIT : ST_DIVIDE;
				end
				ST_DIVIDE: begin
					drem_q <= quo_bit ? drem_sh - {1'b0, total_q} : drem_sh;
					dsh_q  <= {dsh_q[lpw_pkg::WEIGHT_W-2:0], 1'b0};
					quo_q  <= {quo_q[lpw_pkg::WEIGHT_W-2:0], quo_bit};
					step_q <= step_q + 1'b1;
					if (step_q == lpw_pkg::STEP_W'(lpw_pkg::WEIGHT_W - 1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_fire) begin
						out_index_q  <= lpw_pkg::IDX_W'(k_q);
						out_weight_q <= quo_q;
						out_zero_q   <= total_q == '0;
						out_last_q   <= k_nx == count_q;
						if (k_nx == count_q) begin
							k_q     <= '0;
							count_q <= '0;
							total_q <= '0;
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_nx;
							state_q <= ST_FETCH;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[hw/rtl/pixel_level_pmf_weights.sv]
// ----------------------------------------------------------------------------
// pixel_level_pmf_weights
// Per-pixel level magnitudes from image pair differences and variance,
// normalized to Q1.16 weights on the last level of each pixel.
// ----------------------------------------------------------------------------
//  channel   dir   beat contents
//  levels    in    rgb of images k and k+1, pair variance, invalid, last level
//  weights   out   level index, Q1.16 weight, zero total flag, last weight
//
//  front: registered squares, peak select; one level beat per cycle unless stalled
//  back: per level, a queue pop then a 17-step root; no new level is popped
//  until the root is stored, and a level past MAX_LEVELS is dropped unrooted
//  per weight: ram read, load, 17-step divide, emit; no divide on zero total
//  reset clears counts, totals and the queue; the magnitude store is not cleared
//  a stalled weights channel holds the back in emit; the front keeps filling
//  the two-entry queue until it is full
module pixel_level_pmf_weights #(
	parameter int MAX_LEVELS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	lpw_level_if.sink    levels,
	lpw_weight_if.source weights
);

	localparam int AW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

	lpw_pkg::level_job_t        push_job;
	logic                       push_valid;
	logic                       push_ready;
	lpw_pkg::level_job_t        pop_job;
	logic                       pop_valid;
	logic                       pop_ready;
	logic                       ram_we;
	logic [AW-1:0]              ram_waddr;
	logic [lpw_pkg::MAG_W-1:0]  ram_wdata;
	logic [AW-1:0]              ram_raddr;
	logic [lpw_pkg::MAG_W-1:0]  ram_rdata;

	lpw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.levels    (levels),
		.job       (push_job),
		.job_valid (push_valid),
		.job_ready (push_ready)
	);

	lpw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (push_job),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_data   (pop_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	lpw_ram #(
		.WIDTH (lpw_pkg::MAG_W),
		.DEPTH (MAX_LEVELS)
	) u_mag_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	lpw_back #(
		.MAX_LEVELS (MAX_LEVELS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (pop_job),
		.job_valid (pop_valid),
		.job_ready (pop_ready),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.weights   (weights)
	);

	// magnitude writes stay inside the store
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (int'(ram_waddr) < MAX_LEVELS))
		else $error("magnitude write beyond store depth");

	// one write per root, never two in a row
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> !ram_we)
		else $error("back-to-back magnitude writes");

	// zero total forces zero weight
	assert property (@(posedge clk) disable iff (!arst_n)
		(weights.valid && weights.zero_total) |-> (weights.level_weight == '0))
		else $error("nonzero weight with zero total");

	// a weight never exceeds one
	assert property (@(posedge clk) disable iff (!arst_n)
		weights.valid |->
			(weights.level_weight <= lpw_pkg::WEIGHT_W'(2 ** lpw_pkg::FRAC_W)))
		else $error("weight above one");

endmodule
